### rtl/core/cfa_pkg.sv
`timescale 1ns / 1ps
package cfa_pkg;

  localparam int ADDR_W = 20;
  localparam int LEN_W  = 21;
  localparam int TAG_W  = 8;

  localparam logic [LEN_W-1:0] MEM_LIMIT = 21'h100000;

  // request kinds
  localparam logic REQ_ALLOC   = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  // fit strategies (the unused code behaves as first fit)
  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_FIT   = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NO_FOUND = 2'd3;

  typedef struct packed {
    logic              used;
    logic [TAG_W-1:0]  owner;
    logic [ADDR_W-1:0] start;
    logic [LEN_W-1:0]  len;
  } entry_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] start;
    logic [LEN_W-1:0]  len;
  } res_t;

  function automatic entry_t mk_entry(input logic used, input logic [TAG_W-1:0] owner,
                                      input logic [ADDR_W-1:0] start,
                                      input logic [LEN_W-1:0] len);
    entry_t e;
    e.used  = used;
    e.owner = owner;
    e.start = start;
    e.len   = len;
    return e;
  endfunction

endpackage

### rtl/core/cfa_seg_mem.sv
`timescale 1ns / 1ps
module cfa_seg_mem #(
  parameter int DEPTH = 32,
  parameter int IDX_W = 5
) (
  input  logic                clk,
  input  logic                we,
  input  logic [IDX_W-1:0]    waddr,
  input  cfa_pkg::entry_t     wdata,
  input  logic                re,
  input  logic [IDX_W-1:0]    raddr,
  output cfa_pkg::entry_t     rdata
);

  cfa_pkg::entry_t mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/cfa_ctrl.sv
`timescale 1ns / 1ps
module cfa_ctrl #(
  parameter int MAX_SEGMENTS = 32,
  parameter int IDX_W = 5,
  parameter int CNT_W = 6
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [cfa_pkg::LEN_W-1:0]     cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_type,
  input  logic [1:0]                    in_mode,
  input  logic [cfa_pkg::LEN_W-1:0]     in_size,
  input  logic [cfa_pkg::TAG_W-1:0]     in_tag,
  input  logic [cfa_pkg::ADDR_W-1:0]    in_rstart,
  output logic                          res_valid,
  input  logic                          res_ready,
  output cfa_pkg::res_t                 res,
  output logic                          mem_we,
  output logic [IDX_W-1:0]              mem_waddr,
  output cfa_pkg::entry_t               mem_wdata,
  output logic                          mem_re,
  output logic [IDX_W-1:0]              mem_raddr,
  input  cfa_pkg::entry_t               mem_rdata
);

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_MOVE   = 3'd4;
  localparam logic [2:0] S_WR_A   = 3'd5;
  localparam logic [2:0] S_WR_B   = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SEGMENTS);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);

  logic [2:0]                   state_r, state_nxt;
  logic [cfa_pkg::LEN_W-1:0]    msize_r, msize_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic                         rq_type_r, rq_type_nxt;
  logic [1:0]                   rq_mode_r, rq_mode_nxt;
  logic [cfa_pkg::LEN_W-1:0]    rq_size_r, rq_size_nxt;
  logic [cfa_pkg::TAG_W-1:0]    rq_tag_r, rq_tag_nxt;
  logic [cfa_pkg::ADDR_W-1:0]   rq_rstart_r, rq_rstart_nxt;
  logic [CNT_W-1:0]             ptr_r, ptr_nxt;
  logic                         rd_vld_r, rd_vld_nxt;
  logic [CNT_W-1:0]             rd_idx_r, rd_idx_nxt;
  logic                         found_r, found_nxt;
  logic [CNT_W-1:0]             pick_r, pick_nxt;
  cfa_pkg::entry_t              pick_e_r, pick_e_nxt;
  cfa_pkg::entry_t              prev_e_r, prev_e_nxt;
  cfa_pkg::entry_t              hit_prev_r, hit_prev_nxt;
  logic                         prev_free_r, prev_free_nxt;
  logic                         next_pend_r, next_pend_nxt;
  logic                         next_free_r, next_free_nxt;
  logic [cfa_pkg::LEN_W-1:0]    next_len_r, next_len_nxt;
  logic [CNT_W-1:0]             mv_src_r, mv_src_nxt;
  logic [CNT_W-1:0]             mv_left_r, mv_left_nxt;
  logic                         mv_up_r, mv_up_nxt;
  logic [1:0]                   mv_dist_r, mv_dist_nxt;
  logic [2:0]                   mv_next_r, mv_next_nxt;
  logic [2:0]                   wb_next_r, wb_next_nxt;
  cfa_pkg::entry_t              wa_e_r, wa_e_nxt;
  logic [CNT_W-1:0]             wa_idx_r, wa_idx_nxt;
  cfa_pkg::entry_t              wb_e_r, wb_e_nxt;
  logic [CNT_W-1:0]             wb_idx_r, wb_idx_nxt;
  cfa_pkg::res_t                res_r, res_nxt;

  logic                         take;
  logic [CNT_W-1:0]             mv_dst;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_INIT;
      msize_r  <= cfa_pkg::MEM_LIMIT;
      cnt_r    <= CNT_ONE;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      msize_r  <= msize_nxt;
      cnt_r    <= cnt_nxt;
      rd_vld_r <= rd_vld_nxt;
    end
  end

  // request and search payload
  always_ff @(posedge clk) begin
    rq_type_r   <= rq_type_nxt;
    rq_mode_r   <= rq_mode_nxt;
    rq_size_r   <= rq_size_nxt;
    rq_tag_r    <= rq_tag_nxt;
    rq_rstart_r <= rq_rstart_nxt;
    ptr_r       <= ptr_nxt;
    rd_idx_r    <= rd_idx_nxt;
    found_r     <= found_nxt;
    pick_r      <= pick_nxt;
    pick_e_r    <= pick_e_nxt;
    prev_e_r    <= prev_e_nxt;
    hit_prev_r  <= hit_prev_nxt;
    prev_free_r <= prev_free_nxt;
    next_pend_r <= next_pend_nxt;
    next_free_r <= next_free_nxt;
    next_len_r  <= next_len_nxt;
    mv_src_r    <= mv_src_nxt;
    mv_left_r   <= mv_left_nxt;
    mv_up_r     <= mv_up_nxt;
    mv_dist_r   <= mv_dist_nxt;
    mv_next_r   <= mv_next_nxt;
    wb_next_r   <= wb_next_nxt;
    wa_e_r      <= wa_e_nxt;
    wa_idx_r    <= wa_idx_nxt;
    wb_e_r      <= wb_e_nxt;
    wb_idx_r    <= wb_idx_nxt;
    res_r       <= res_nxt;
  end

  // candidate test for the fit search
  always_comb begin
    take = !mem_rdata.used && (mem_rdata.len >= rq_size_r) &&
           (!found_r ||
            (rq_mode_r == cfa_pkg::FIT_BEST  && mem_rdata.len < pick_e_r.len) ||
            (rq_mode_r == cfa_pkg::FIT_WORST && mem_rdata.len > pick_e_r.len));
  end

  assign mv_dst = mv_up_r ? rd_idx_r + CNT_W'(mv_dist_r) : rd_idx_r - CNT_W'(mv_dist_r);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    msize_nxt     = msize_r;
    cnt_nxt       = cnt_r;
    rq_type_nxt   = rq_type_r;
    rq_mode_nxt   = rq_mode_r;
    rq_size_nxt   = rq_size_r;
    rq_tag_nxt    = rq_tag_r;
    rq_rstart_nxt = rq_rstart_r;
    ptr_nxt       = ptr_r;
    rd_vld_nxt    = rd_vld_r;
    rd_idx_nxt    = rd_idx_r;
    found_nxt     = found_r;
    pick_nxt      = pick_r;
    pick_e_nxt    = pick_e_r;
    prev_e_nxt    = prev_e_r;
    hit_prev_nxt  = hit_prev_r;
    prev_free_nxt = prev_free_r;
    next_pend_nxt = next_pend_r;
    next_free_nxt = next_free_r;
    next_len_nxt  = next_len_r;
    mv_src_nxt    = mv_src_r;
    mv_left_nxt   = mv_left_r;
    mv_up_nxt     = mv_up_r;
    mv_dist_nxt   = mv_dist_r;
    mv_next_nxt   = mv_next_r;
    wb_next_nxt   = wb_next_r;
    wa_e_nxt      = wa_e_r;
    wa_idx_nxt    = wa_idx_r;
    wb_e_nxt      = wb_e_r;
    wb_idx_nxt    = wb_idx_r;
    res_nxt       = res_r;
    in_ready      = 1'b0;
    res_valid     = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = wa_idx_r[IDX_W-1:0];
    mem_wdata     = wa_e_r;
    mem_re        = 1'b0;
    mem_raddr     = ptr_r[IDX_W-1:0];

    case (state_r)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = cfa_pkg::mk_entry(1'b0, '0, '0, msize_r);
        cnt_nxt   = CNT_ONE;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          rq_type_nxt   = in_type;
          rq_mode_nxt   = in_mode;
          rq_size_nxt   = in_size;
          rq_tag_nxt    = in_tag;
          rq_rstart_nxt = in_rstart;
          ptr_nxt       = '0;
          rd_vld_nxt    = 1'b0;
          found_nxt     = 1'b0;
          prev_free_nxt = 1'b0;
          next_pend_nxt = 1'b0;
          next_free_nxt = 1'b0;
          if (in_type == cfa_pkg::REQ_ALLOC && in_size == '0) begin
            res_nxt   = '{status: cfa_pkg::ST_NO_FIT, start: '0, len: '0};
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // one read issued per cycle, its data examined once the registered read returns
        mem_raddr  = ptr_r[IDX_W-1:0];
        mem_re     = (ptr_r < cnt_r);
        rd_vld_nxt = (ptr_r < cnt_r);
        rd_idx_nxt = ptr_r;
        if (ptr_r < cnt_r) begin
          ptr_nxt = ptr_r + CNT_ONE;
        end
        if (rd_vld_r) begin
          prev_e_nxt = mem_rdata;
          if (rq_type_r == cfa_pkg::REQ_RELEASE) begin
            if (!found_r && mem_rdata.used && mem_rdata.start == rq_rstart_r) begin
              found_nxt     = 1'b1;
              pick_nxt      = rd_idx_r;
              pick_e_nxt    = mem_rdata;
              hit_prev_nxt  = prev_e_r;
              prev_free_nxt = (rd_idx_r != '0) && !prev_e_r.used;
              next_pend_nxt = 1'b1;
            end else if (next_pend_r) begin
              next_pend_nxt = 1'b0;
              next_free_nxt = !mem_rdata.used;
              next_len_nxt  = mem_rdata.len;
            end
          end else if (take) begin
            found_nxt  = 1'b1;
            pick_nxt   = rd_idx_r;
            pick_e_nxt = mem_rdata;
          end
          if (rd_idx_r == cnt_r - CNT_ONE) begin
            state_nxt = S_DECIDE;
          end
        end
      end
      S_DECIDE: begin
        rd_vld_nxt = 1'b0;
        if (rq_type_r == cfa_pkg::REQ_ALLOC) begin
          wb_idx_nxt  = pick_r;
          wb_e_nxt    = cfa_pkg::mk_entry(1'b1, rq_tag_r, pick_e_r.start, rq_size_r);
          wb_next_nxt = S_DONE;
          res_nxt     = '{status: cfa_pkg::ST_OK, start: pick_e_r.start, len: rq_size_r};
          if (!found_r) begin
            res_nxt   = '{status: cfa_pkg::ST_NO_FIT, start: '0, len: '0};
            state_nxt = S_DONE;
          end else if (pick_e_r.len > rq_size_r) begin
            if (cnt_r == CNT_MAX) begin
              res_nxt   = '{status: cfa_pkg::ST_FULL, start: '0, len: '0};
              state_nxt = S_DONE;
            end else begin
              // open a slot after the pick for the free remainder
              mv_src_nxt  = cnt_r - CNT_ONE;
              mv_left_nxt = cnt_r - CNT_ONE - pick_r;
              mv_up_nxt   = 1'b1;
              mv_dist_nxt = 2'd1;
              mv_next_nxt = S_WR_A;
              wa_idx_nxt  = pick_r + CNT_ONE;
              wa_e_nxt    = cfa_pkg::mk_entry(1'b0, '0,
                              pick_e_r.start + rq_size_r[cfa_pkg::ADDR_W-1:0],
                              pick_e_r.len - rq_size_r);
              cnt_nxt     = cnt_r + CNT_ONE;
              state_nxt   = S_MOVE;
            end
          end else begin
            state_nxt = S_WR_B;
          end
        end else begin
          mv_up_nxt   = 1'b0;
          mv_next_nxt = S_DONE;
          wb_next_nxt = S_MOVE;
          mv_left_nxt = '0;
          mv_dist_nxt = 2'd1;
          res_nxt     = '{status: cfa_pkg::ST_OK, start: pick_e_r.start, len: pick_e_r.len};
          if (!found_r) begin
            res_nxt   = '{status: cfa_pkg::ST_NO_FOUND, start: '0, len: '0};
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_WR_B;
            if (prev_free_r && next_free_r) begin
              // merge both neighbours into the left one
              wb_idx_nxt  = pick_r - CNT_ONE;
              wb_e_nxt    = cfa_pkg::mk_entry(1'b0, '0, hit_prev_r.start,
                              hit_prev_r.len + pick_e_r.len + next_len_r);
              mv_src_nxt  = pick_r + CNT_TWO;
              mv_left_nxt = cnt_r - pick_r - CNT_TWO;
              mv_dist_nxt = 2'd2;
              cnt_nxt     = cnt_r - CNT_TWO;
            end else if (next_free_r) begin
              wb_idx_nxt  = pick_r;
              wb_e_nxt    = cfa_pkg::mk_entry(1'b0, '0, pick_e_r.start,
                              pick_e_r.len + next_len_r);
              mv_src_nxt  = pick_r + CNT_TWO;
              mv_left_nxt = cnt_r - pick_r - CNT_TWO;
              cnt_nxt     = cnt_r - CNT_ONE;
            end else if (prev_free_r) begin
              wb_idx_nxt  = pick_r - CNT_ONE;
              wb_e_nxt    = cfa_pkg::mk_entry(1'b0, '0, hit_prev_r.start,
                              hit_prev_r.len + pick_e_r.len);
              mv_src_nxt  = pick_r + CNT_ONE;
              mv_left_nxt = cnt_r - pick_r - CNT_ONE;
              cnt_nxt     = cnt_r - CNT_ONE;
            end else begin
              wb_idx_nxt = pick_r;
              wb_e_nxt   = cfa_pkg::mk_entry(1'b0, '0, pick_e_r.start, pick_e_r.len);
            end
          end
        end
      end
      S_MOVE: begin
        // pipelined copy: read one entry, write the previous one moved
        mem_raddr  = mv_src_r[IDX_W-1:0];
        mem_re     = (mv_left_r != '0);
        rd_vld_nxt = (mv_left_r != '0);
        rd_idx_nxt = mv_src_r;
        if (mv_left_r != '0) begin
          mv_left_nxt = mv_left_r - CNT_ONE;
          mv_src_nxt  = mv_up_r ? mv_src_r - CNT_ONE : mv_src_r + CNT_ONE;
        end
        if (rd_vld_r) begin
          mem_we    = 1'b1;
          mem_waddr = mv_dst[IDX_W-1:0];
          mem_wdata = mem_rdata;
        end
        if (mv_left_r == '0 && !rd_vld_r) begin
          state_nxt = mv_next_r;
        end
      end
      S_WR_A: begin
        mem_we    = 1'b1;
        mem_waddr = wa_idx_r[IDX_W-1:0];
        mem_wdata = wa_e_r;
        state_nxt = S_WR_B;
      end
      S_WR_B: begin
        mem_we    = 1'b1;
        mem_waddr = wb_idx_r[IDX_W-1:0];
        mem_wdata = wb_e_r;
        state_nxt = wb_next_r;
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase

    // size write rebuilds the table
    if (cfg_wr_en) begin
      if (cfg_wr_data == '0) begin
        msize_nxt = cfa_pkg::LEN_W'(1);
      end else if (cfg_wr_data > cfa_pkg::MEM_LIMIT) begin
        msize_nxt = cfa_pkg::MEM_LIMIT;
      end else begin
        msize_nxt = cfg_wr_data;
      end
      state_nxt = S_INIT;
    end
  end

  assign res = res_r;

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != '0 && cnt_r <= CNT_MAX)
    else $error("segment count out of range");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re && mem_waddr == mem_raddr))
    else $error("read and write to the same entry in one cycle");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_r.status != cfa_pkg::ST_OK |-> res_r.start == '0 && res_r.len == '0)
    else $error("error result with non-zero fields");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_ready && !cfg_wr_en |=> res_valid && $stable(res_r))
    else $error("result dropped while stalled");
`endif

endmodule

### rtl/core/contiguous_fit_allocator.sv
`timescale 1ns / 1ps
// contiguous segment allocator
// in channel: one request per handshake, allocate (first, best or worst fit)
//   or release by start address; out channel: one result per request
// cfg port: write of memory_size rebuilds the table to one free segment
// the table lives in a single one-read one-write memory; every request
// scans all table entries one a cycle, then a split shifts entries up
// or a release merge shifts them down, one entry a cycle, plus one or
// two writes for the changed entries
// a zero-size allocation is answered without a scan
// one request is worked on at a time; a new one is taken as soon as the
// previous result has moved to the output register
// reset (and every size write) writes entry 0 in the INIT state; reset
// leaves memory_size at 1048576, a size write clamps it to 1..1048576
// when the receiver stalls the output register holds the result, one more
// result waits inside, and then in_tready stays low
module contiguous_fit_allocator #(
  parameter int MAX_SEGMENTS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [20:0] cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // req_size[20:0], owner_tag[28:21], release_start[48:29]
  input  logic [2:0]  in_tuser,   // req_type[0], fit_mode[2:1]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // seg_start[19:0], seg_length[40:20]
  output logic [1:0]  out_tuser   // status[1:0]
);

  localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  cfa_pkg::entry_t    mem_wdata;
  logic               mem_re;
  logic [IDX_W-1:0]   mem_raddr;
  cfa_pkg::entry_t    mem_rdata;
  logic               res_valid;
  logic               res_ready;
  cfa_pkg::res_t      res;

  logic               out_valid_r, out_valid_nxt;
  cfa_pkg::res_t      out_res_r, out_res_nxt;

  cfa_seg_mem #(
    .DEPTH (MAX_SEGMENTS),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  cfa_ctrl #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .IDX_W        (IDX_W),
    .CNT_W        (CNT_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_type     (in_tuser[0]),
    .in_mode     (in_tuser[2:1]),
    .in_size     (in_tdata[20:0]),
    .in_tag      (in_tdata[28:21]),
    .in_rstart   (in_tdata[48:29]),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata)
  );

  // output register
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {7'd0, out_res_r.len, out_res_r.start};

endmodule
